### rtl/pwd_pkg.sv
// Shared types, constants and the child coefficient table for the pinwheel deflation unit.
// Used by every module of the block; depends on nothing.
package pwd_pkg;

    // Coordinate format
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 20;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int NW_BITS    = COORD_BITS + FRAC_BITS;
    localparam int CW_BITS    = FRAC_BITS + 4;
    localparam int PROD_BITS  = DIFF_BITS + CW_BITS;
    localparam int CROSS_BITS = 2 * DIFF_BITS + 1;

    // Children
    localparam int NUM_KIDS    = 5;
    localparam int KID_BITS    = 3;
    localparam int NUM_CORNERS = 3;
    localparam logic [KID_BITS-1:0] FIRST_KID = '0;
    localparam logic [KID_BITS-1:0] LAST_KID  = KID_BITS'(NUM_KIDS - 1);

    // Corner codes
    localparam logic [1:0] CORNER_SMALL  = 2'd0;
    localparam logic [1:0] CORNER_RIGHT  = 2'd1;
    localparam logic [1:0] CORNER_MEDIUM = 2'd2;

    // Rounded 0.2 and 0.4, and the rounding half LSB
    localparam longint K_FIFTH      = ((longint'(2) << FRAC_BITS) + 5) / 10;
    localparam longint K_TWO_FIFTHS = ((longint'(4) << FRAC_BITS) + 5) / 10;
    localparam logic [NW_BITS-1:0] HALF_LSB = NW_BITS'(1) << (FRAC_BITS - 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } dpoint_t;

    // Per-axis product terms of one child corner
    typedef struct packed {
        logic signed [NW_BITS-1:0] pw;
        logic signed [DIFF_BITS:0] un;
    } term_t;

    typedef struct packed {
        term_t x;
        term_t y;
    } term_pair_t;

    // Control tag that travels with each child through the stages
    typedef struct packed {
        logic                valid;
        logic [KID_BITS-1:0] kid;
    } pwd_tag_t;

    typedef struct packed {
        logic signed [3:0] a;
        logic signed [3:0] b;
    } ab_t;

    // (a, b) for each child and corner
    function automatic ab_t kid_ab(input logic [KID_BITS-1:0] kid, input logic [1:0] corner);
        ab_t r;
        r.a = 4'sd0;
        r.b = 4'sd0;
        case ({kid, corner})
            {3'd0, CORNER_SMALL}:  begin r.a = 4'sd0; r.b = 4'sd0;  end
            {3'd0, CORNER_RIGHT}:  begin r.a = 4'sd2; r.b = 4'sd0;  end
            {3'd0, CORNER_MEDIUM}: begin r.a = 4'sd2; r.b = -4'sd1; end
            {3'd1, CORNER_SMALL}:  begin r.a = 4'sd4; r.b = 4'sd0;  end
            {3'd1, CORNER_RIGHT}:  begin r.a = 4'sd2; r.b = 4'sd0;  end
            {3'd1, CORNER_MEDIUM}: begin r.a = 4'sd2; r.b = -4'sd1; end
            {3'd2, CORNER_SMALL}:  begin r.a = 4'sd2; r.b = -4'sd1; end
            {3'd2, CORNER_RIGHT}:  begin r.a = 4'sd4; r.b = -4'sd1; end
            {3'd2, CORNER_MEDIUM}: begin r.a = 4'sd4; r.b = 4'sd0;  end
            {3'd3, CORNER_SMALL}:  begin r.a = 4'sd2; r.b = -4'sd1; end
            {3'd3, CORNER_RIGHT}:  begin r.a = 4'sd4; r.b = -4'sd1; end
            {3'd3, CORNER_MEDIUM}: begin r.a = 4'sd4; r.b = -4'sd2; end
            {3'd4, CORNER_SMALL}:  begin r.a = 4'sd4; r.b = -4'sd2; end
            {3'd4, CORNER_RIGHT}:  begin r.a = 4'sd4; r.b = 4'sd0;  end
            {3'd4, CORNER_MEDIUM}: begin r.a = 4'sd5; r.b = 4'sd0;  end
            default:               begin r.a = 4'sd0; r.b = 4'sd0;  end
        endcase
        return r;
    endfunction

    // Weight on W: a*K_FIFTH + b*K_TWO_FIFTHS
    function automatic logic signed [CW_BITS-1:0] kid_cw(input logic [KID_BITS-1:0] kid,
                                                         input logic [1:0] corner);
        ab_t    r;
        longint t;
        r = kid_ab(kid, corner);
        t = longint'(r.a) * K_FIFTH + longint'(r.b) * K_TWO_FIFTHS;
        return CW_BITS'(t);
    endfunction

    // Multiple of U (times one half): -b, one of 0, 1, 2
    function automatic logic [1:0] kid_nb(input logic [KID_BITS-1:0] kid,
                                          input logic [1:0] corner);
        ab_t               r;
        logic signed [3:0] nb;
        r  = kid_ab(kid, corner);
        nb = -r.b;
        return nb[1:0];
    endfunction

endpackage

### rtl/pwd_issue.sv
// Parent register, child sequencer and first product stage of the deflation unit.
// Depends on pwd_pkg.
module pwd_issue
    import pwd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  coord_t                  small_x,
    input  coord_t                  small_y,
    input  coord_t                  right_x,
    input  coord_t                  right_y,
    input  coord_t                  medium_x,
    input  coord_t                  medium_y,
    output pwd_tag_t                tag1,
    output point_t                  s1,
    output term_pair_t [2:0]        terms1
);

    logic                par_valid_reg, par_valid_next;
    logic [KID_BITS-1:0] kid_reg, kid_next;
    point_t              s_reg;
    dpoint_t             w_reg;
    dpoint_t             u_reg;

    logic                issue;
    logic                done;
    logic                take;

    pwd_tag_t            tag1_reg;
    point_t              s1_reg;
    term_pair_t [2:0]    terms1_reg, terms1_next;

    // Issue one child per advancing cycle; free the parent slot on the last one
    assign issue    = par_valid_reg && adv;
    assign done     = issue && (kid_reg == LAST_KID);
    assign in_stall = par_valid_reg && !done;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        par_valid_next = par_valid_reg;
        kid_next       = kid_reg;
        if (take)
        begin
            par_valid_next = 1'b1;
            kid_next       = FIRST_KID;
        end
        else if (done)
        begin
            par_valid_next = 1'b0;
        end
        else if (issue)
        begin
            kid_next = kid_reg + KID_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_valid_reg <= 1'b0;
            kid_reg       <= FIRST_KID;
        end
        else
        begin
            par_valid_reg <= par_valid_next;
            kid_reg       <= kid_next;
        end
    end

    // Hold the parent as S, W = M - S and U = L - S
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_reg.x <= small_x;
            s_reg.y <= small_y;
            w_reg.x <= DIFF_BITS'(medium_x) - DIFF_BITS'(small_x);
            w_reg.y <= DIFF_BITS'(medium_y) - DIFF_BITS'(small_y);
            u_reg.x <= DIFF_BITS'(right_x) - DIFF_BITS'(small_x);
            u_reg.y <= DIFF_BITS'(right_y) - DIFF_BITS'(small_y);
        end
    end

    // Form W times the corner weight and the U multiple for each corner
    always_comb
    begin
        logic signed [CW_BITS-1:0]   cw;
        logic [1:0]                  nb;
        logic signed [PROD_BITS-1:0] px;
        logic signed [PROD_BITS-1:0] py;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            cw = kid_cw(kid_reg, 2'(c));
            nb = kid_nb(kid_reg, 2'(c));
            px = w_reg.x * cw;
            py = w_reg.y * cw;
            terms1_next[c].x.pw = px[NW_BITS-1:0];
            terms1_next[c].y.pw = py[NW_BITS-1:0];
            case (nb)
                2'd2:
                begin
                    terms1_next[c].x.un = {u_reg.x, 1'b0};
                    terms1_next[c].y.un = {u_reg.y, 1'b0};
                end
                2'd1:
                begin
                    terms1_next[c].x.un = {u_reg.x[DIFF_BITS-1], u_reg.x};
                    terms1_next[c].y.un = {u_reg.y[DIFF_BITS-1], u_reg.y};
                end
                default:
                begin
                    terms1_next[c].x.un = '0;
                    terms1_next[c].y.un = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg.valid <= par_valid_reg;
            tag1_reg.kid   <= kid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s_reg;
            terms1_reg <= terms1_next;
        end
    end

    assign tag1   = tag1_reg;
    assign s1     = s1_reg;
    assign terms1 = terms1_reg;

endmodule

### rtl/pwd_corner.sv
// Rounding sum and corner add stages of the deflation unit.
// Depends on pwd_pkg.
module pwd_corner
    import pwd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  pwd_tag_t                tag1,
    input  point_t                  s1,
    input  term_pair_t [2:0]        terms1,
    output pwd_tag_t                tag3,
    output point_t [2:0]            tri3
);

    pwd_tag_t      tag2_reg;
    point_t        s2_reg;
    point_t [2:0]  off2_reg, off2_next;

    pwd_tag_t      tag3_reg;
    point_t [2:0]  tri3_reg, tri3_next;

    // Sum both terms with the half LSB and keep the integer-aligned bits
    always_comb
    begin
        logic [NW_BITS:0]   ux;
        logic [NW_BITS:0]   uy;
        logic [NW_BITS-1:0] rx;
        logic [NW_BITS-1:0] ry;
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            ux = {terms1[c].x.un, {(FRAC_BITS-1){1'b0}}};
            uy = {terms1[c].y.un, {(FRAC_BITS-1){1'b0}}};
            rx = terms1[c].x.pw + ux[NW_BITS-1:0] + HALF_LSB;
            ry = terms1[c].y.pw + uy[NW_BITS-1:0] + HALF_LSB;
            off2_next[c].x = rx[NW_BITS-1:FRAC_BITS];
            off2_next[c].y = ry[NW_BITS-1:FRAC_BITS];
        end
    end

    // Add the parent small corner
    always_comb
    begin
        for (int c = 0; c < NUM_CORNERS; c++)
        begin
            tri3_next[c].x = s2_reg.x + off2_reg[c].x;
            tri3_next[c].y = s2_reg.y + off2_reg[c].y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag2_reg <= tag1;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg   <= s1;
            off2_reg <= off2_next;
            tri3_reg <= tri3_next;
        end
    end

    assign tag3 = tag3_reg;
    assign tri3 = tri3_reg;

endmodule

### rtl/pwd_orient.sv
// Edge difference, cross product and output register stages of the deflation unit.
// Depends on pwd_pkg.
module pwd_orient
    import pwd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  pwd_tag_t                tag3,
    input  point_t [2:0]            tri3,
    output pwd_tag_t                tag_out,
    output point_t [2:0]            tri_out,
    output logic                    mirr_out,
    output logic                    last_out
);

    pwd_tag_t      tag4_reg;
    point_t [2:0]  tri4_reg;
    dpoint_t       e1_reg, e1_next;
    dpoint_t       e2_reg, e2_next;

    pwd_tag_t                       tag5_reg;
    point_t [2:0]                   tri5_reg;
    logic signed [2*DIFF_BITS-1:0]  p1_reg, p1_next;
    logic signed [2*DIFF_BITS-1:0]  p2_reg, p2_next;

    pwd_tag_t                       out_tag_reg;
    point_t [2:0]                   out_tri_reg;
    logic                           mirr_reg, mirr_next;
    logic                           last_reg;
    logic signed [CROSS_BITS-1:0]   cross_sum;

    // Edges from the child small corner
    always_comb
    begin
        e1_next.x = DIFF_BITS'(tri3[CORNER_RIGHT].x)  - DIFF_BITS'(tri3[CORNER_SMALL].x);
        e1_next.y = DIFF_BITS'(tri3[CORNER_RIGHT].y)  - DIFF_BITS'(tri3[CORNER_SMALL].y);
        e2_next.x = DIFF_BITS'(tri3[CORNER_MEDIUM].x) - DIFF_BITS'(tri3[CORNER_SMALL].x);
        e2_next.y = DIFF_BITS'(tri3[CORNER_MEDIUM].y) - DIFF_BITS'(tri3[CORNER_SMALL].y);
    end

    // Cross product halves
    assign p1_next = e1_reg.x * e2_reg.y;
    assign p2_next = e1_reg.y * e2_reg.x;

    // Negative cross marks a mirrored child
    assign cross_sum = CROSS_BITS'(p1_reg) - CROSS_BITS'(p2_reg);
    assign mirr_next = cross_sum[CROSS_BITS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag4_reg    <= '0;
            tag5_reg    <= '0;
            out_tag_reg <= '0;
        end
        else if (adv)
        begin
            tag4_reg    <= tag3;
            tag5_reg    <= tag4_reg;
            out_tag_reg <= tag5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tri4_reg    <= tri3;
            e1_reg      <= e1_next;
            e2_reg      <= e2_next;
            tri5_reg    <= tri4_reg;
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            out_tri_reg <= tri5_reg;
            mirr_reg    <= mirr_next;
            last_reg    <= (tag5_reg.kid == LAST_KID);
        end
    end

    assign tag_out  = out_tag_reg;
    assign tri_out  = out_tri_reg;
    assign mirr_out = mirr_reg;
    assign last_out = last_reg;

endmodule

### rtl/pinwheel_triangle_deflation_unit.sv
// Pinwheel triangle deflation: one parent triangle in, five child triangles out.
// The child sequencer issues children of the held parent through the product, rounding
// sum, corner add, edge difference, cross product and output register stages in order.
// One child per cycle unless the output stalls; a new parent enters as the last one issues.
// Reset (rst_n low, asynchronous) clears the parent slot and all stage valid bits.
// Depends on pwd_pkg, pwd_issue, pwd_corner and pwd_orient.
module pinwheel_triangle_deflation_unit
    import pwd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  coord_t              small_x,
    input  coord_t              small_y,
    input  coord_t              right_x,
    input  coord_t              right_y,
    input  coord_t              medium_x,
    input  coord_t              medium_y,
    output logic                out_valid,
    input  logic                out_stall,
    output coord_t              child_small_x,
    output coord_t              child_small_y,
    output coord_t              child_right_x,
    output coord_t              child_right_y,
    output coord_t              child_medium_x,
    output coord_t              child_medium_y,
    output logic                mirrored,
    output logic [KID_BITS-1:0] child_index,
    output logic                last_child
);

    logic              adv;
    pwd_tag_t          tag1;
    point_t            s1;
    term_pair_t [2:0]  terms1;
    pwd_tag_t          tag3;
    point_t [2:0]      tri3;
    pwd_tag_t          tag_out;
    point_t [2:0]      tri_out;

    // Advance all stages unless a finished child is held at the output
    assign adv = !tag_out.valid || !out_stall;

    pwd_issue u_issue (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .small_x  (small_x),
        .small_y  (small_y),
        .right_x  (right_x),
        .right_y  (right_y),
        .medium_x (medium_x),
        .medium_y (medium_y),
        .tag1     (tag1),
        .s1       (s1),
        .terms1   (terms1)
    );

    pwd_corner u_corner (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .tag1   (tag1),
        .s1     (s1),
        .terms1 (terms1),
        .tag3   (tag3),
        .tri3   (tri3)
    );

    pwd_orient u_orient (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .tag3     (tag3),
        .tri3     (tri3),
        .tag_out  (tag_out),
        .tri_out  (tri_out),
        .mirr_out (mirrored),
        .last_out (last_child)
    );

    assign out_valid      = tag_out.valid;
    assign child_index    = tag_out.kid;
    assign child_small_x  = tri_out[CORNER_SMALL].x;
    assign child_small_y  = tri_out[CORNER_SMALL].y;
    assign child_right_x  = tri_out[CORNER_RIGHT].x;
    assign child_right_y  = tri_out[CORNER_RIGHT].y;
    assign child_medium_x = tri_out[CORNER_MEDIUM].x;
    assign child_medium_y = tri_out[CORNER_MEDIUM].y;

endmodule

### rtl/pwd_checker.sv
// Port-level checks for the pinwheel deflation unit, bound to its top level.
// Depends on pwd_pkg.
module pwd_checker
    import pwd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  coord_t              child_small_x,
    input  coord_t              child_small_y,
    input  coord_t              child_right_x,
    input  coord_t              child_right_y,
    input  coord_t              child_medium_x,
    input  coord_t              child_medium_y,
    input  logic                mirrored,
    input  logic [KID_BITS-1:0] child_index,
    input  logic                last_child
);

    // Hold a stalled child
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(child_small_x)
            && $stable(child_small_y) && $stable(child_right_x) && $stable(child_right_y)
            && $stable(child_medium_x) && $stable(child_medium_y) && $stable(mirrored)
            && $stable(child_index))
        else $error("stalled child changed");

    // Mark only the final child as last
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_child == (child_index == LAST_KID)))
        else $error("last marker does not match child index");

    // Follow a taken child with the next one of the same parent
    a_next_child: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_child
            |=> out_valid && (child_index == $past(child_index) + KID_BITS'(1)))
        else $error("children of one parent not back to back");

    // Block the next parent while the current one is still being split
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second parent taken right after the first");

endmodule

bind pinwheel_triangle_deflation_unit pwd_checker u_pwd_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for pinwheel_triangle_deflation_unit: parents in, five children out.
// Depends on pwd_pkg for coordinate types and the corner codes.
module testbench;
    import pwd_pkg::*;

    localparam int     RUN_LIMIT    = 200000;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     HOLD_AFTER   = 120;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     RANDOM_ITEMS = 500;
    localparam int     MAX_REPORTS  = 10;
    localparam longint FIFTH_Q      = ((longint'(2) << FRAC_BITS) + 5) / 10;
    localparam longint TWO_FIFTHS_Q = ((longint'(4) << FRAC_BITS) + 5) / 10;
    localparam longint HALF_Q       = longint'(1) << (FRAC_BITS - 1);
    localparam longint COORD_MAX    = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN    = -COORD_MAX - 1;
    localparam longint UNIT         = longint'(1) << FRAC_BITS;

    typedef struct packed {
        point_t s;
        point_t l;
        point_t m;
    } parent_t;

    typedef struct packed {
        coord_t              sx;
        coord_t              sy;
        coord_t              rx;
        coord_t              ry;
        coord_t              mx;
        coord_t              my;
        logic                mir;
        logic [KID_BITS-1:0] idx;
        logic                last;
    } child_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    coord_t              small_x = '0;
    coord_t              small_y = '0;
    coord_t              right_x = '0;
    coord_t              right_y = '0;
    coord_t              medium_x = '0;
    coord_t              medium_y = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    coord_t              child_small_x;
    coord_t              child_small_y;
    coord_t              child_right_x;
    coord_t              child_right_y;
    coord_t              child_medium_x;
    coord_t              child_medium_y;
    logic                mirrored;
    logic [KID_BITS-1:0] child_index;
    logic                last_child;

    parent_t parents_to_send[$];
    child_t  children_due[$];

    int   cycle_count = 0;
    int   parents_taken = 0;
    int   children_checked = 0;
    int   mirrored_seen = 0;
    int   input_stall_cycles = 0;
    int   mismatch_count = 0;
    int   send_gap = 0;
    int   rcv_wait = 0;
    logic sender_steady = 1'b0;
    logic receiver_steady = 1'b0;
    logic hold_out = 1'b0;

    pinwheel_triangle_deflation_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .small_x        (small_x),
        .small_y        (small_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .medium_x       (medium_x),
        .medium_y       (medium_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .child_small_x  (child_small_x),
        .child_small_y  (child_small_y),
        .child_right_x  (child_right_x),
        .child_right_y  (child_right_y),
        .child_medium_x (child_medium_x),
        .child_medium_y (child_medium_y),
        .mirrored       (mirrored),
        .child_index    (child_index),
        .last_child     (last_child)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // One corner on one axis: S plus the weighted edges, rounded once (ties up)
    function automatic coord_t scaled_corner(input coord_t s, input longint w, input longint u,
                                             input int a, input int nb);
        longint n;
        n = w * (a * FIFTH_Q - nb * TWO_FIFTHS_Q) + u * (nb * HALF_Q);
        return coord_t'(longint'(s) + ((n + HALF_Q) >>> FRAC_BITS));
    endfunction

    // Expand one parent into its five children and queue them in emit order
    function automatic void deflate_parent(input parent_t p);
        longint          ux;
        longint          uy;
        longint          wx;
        longint          wy;
        longint          turn;
        logic [2:0][3:0] a_row;
        logic [2:0][3:0] nb_row;
        coord_t          cx [NUM_CORNERS];
        coord_t          cy [NUM_CORNERS];
        child_t          c;
        ux = longint'(p.l.x) - longint'(p.s.x);
        uy = longint'(p.l.y) - longint'(p.s.y);
        wx = longint'(p.m.x) - longint'(p.s.x);
        wy = longint'(p.m.y) - longint'(p.s.y);
        for (int kid = 0; kid < NUM_KIDS; kid++)
        begin
            // weights per corner, packed as {medium, right, small}; nb is minus b
            case (kid)
                0:       begin a_row = {4'd2, 4'd2, 4'd0}; nb_row = {4'd1, 4'd0, 4'd0}; end
                1:       begin a_row = {4'd2, 4'd2, 4'd4}; nb_row = {4'd1, 4'd0, 4'd0}; end
                2:       begin a_row = {4'd4, 4'd4, 4'd2}; nb_row = {4'd0, 4'd1, 4'd1}; end
                3:       begin a_row = {4'd4, 4'd4, 4'd2}; nb_row = {4'd2, 4'd1, 4'd1}; end
                default: begin a_row = {4'd5, 4'd4, 4'd4}; nb_row = {4'd0, 4'd0, 4'd2}; end
            endcase
            for (int cn = 0; cn < NUM_CORNERS; cn++)
            begin
                cx[cn] = scaled_corner(p.s.x, wx, ux, a_row[cn], nb_row[cn]);
                cy[cn] = scaled_corner(p.s.y, wy, uy, a_row[cn], nb_row[cn]);
            end
            turn = (longint'(cx[CORNER_RIGHT]) - longint'(cx[CORNER_SMALL]))
                 * (longint'(cy[CORNER_MEDIUM]) - longint'(cy[CORNER_SMALL]))
                 - (longint'(cy[CORNER_RIGHT]) - longint'(cy[CORNER_SMALL]))
                 * (longint'(cx[CORNER_MEDIUM]) - longint'(cx[CORNER_SMALL]));
            c.sx   = cx[CORNER_SMALL];
            c.sy   = cy[CORNER_SMALL];
            c.rx   = cx[CORNER_RIGHT];
            c.ry   = cy[CORNER_RIGHT];
            c.mx   = cx[CORNER_MEDIUM];
            c.my   = cy[CORNER_MEDIUM];
            c.mir  = (turn < 0);
            c.idx  = KID_BITS'(kid);
            c.last = (KID_BITS'(kid) == LAST_KID);
            children_due = {children_due, c};
        end
    endfunction

    function automatic string child_text(input child_t c);
        return $sformatf("#%0d S(%0d,%0d) R(%0d,%0d) M(%0d,%0d) mir=%0b last=%0b",
                         c.idx, c.sx, c.sy, c.rx, c.ry, c.mx, c.my, c.mir, c.last);
    endfunction

    function automatic void add_parent(input longint sx, input longint sy, input longint rx,
                                       input longint ry, input longint mx, input longint my);
        parent_t p;
        p.s.x = coord_t'(sx);
        p.s.y = coord_t'(sy);
        p.l.x = coord_t'(rx);
        p.l.y = coord_t'(ry);
        p.m.x = coord_t'(mx);
        p.m.y = coord_t'(my);
        parents_to_send = {parents_to_send, p};
    endfunction

    function automatic longint random_coord();
        return longint'(coord_t'($urandom));
    endfunction

    // Mostly the range ends and values around zero
    function automatic longint edge_coord();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            default: return random_coord();
        endcase
    endfunction

    // Offer parents; hold the payload while stalled, then idle for the drawn gap
    always @(posedge clk or negedge rst_n)
    begin : parent_driver
        parent_t p;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (parents_to_send.size() != 0)
            begin
                p = parents_to_send.pop_front();
                small_x  <= p.s.x;
                small_y  <= p.s.y;
                right_x  <= p.l.x;
                right_y  <= p.l.y;
                medium_x <= p.m.x;
                medium_y <= p.m.y;
                in_valid <= 1'b1;
                send_gap <= (sender_steady || hold_out) ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    sender_steady <= !sender_steady;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Stall the output for a drawn number of cycles after each child, or during the long hold
    always @(posedge clk or negedge rst_n)
    begin : child_receiver
        int remaining;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rcv_wait  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                remaining = receiver_steady ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    receiver_steady <= !receiver_steady;
            end
            else
            begin
                remaining = rcv_wait;
            end
            out_stall <= hold_out || (remaining != 0);
            rcv_wait  <= (remaining != 0) ? remaining - 1 : 0;
        end
    end

    // Predict on every taken parent, check every taken child against the oldest prediction
    always @(posedge clk)
    begin : child_monitor
        parent_t p;
        child_t  got;
        child_t  want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                p.s.x = small_x;
                p.s.y = small_y;
                p.l.x = right_x;
                p.l.y = right_y;
                p.m.x = medium_x;
                p.m.y = medium_y;
                deflate_parent(p);
                parents_taken++;
            end
            if (in_valid && in_stall)
                input_stall_cycles++;
            if (out_valid && !out_stall)
            begin
                got.sx   = child_small_x;
                got.sy   = child_small_y;
                got.rx   = child_right_x;
                got.ry   = child_right_y;
                got.mx   = child_medium_x;
                got.my   = child_medium_y;
                got.mir  = mirrored;
                got.idx  = child_index;
                got.last = last_child;
                if (mirrored === 1'b1)
                    mirrored_seen++;
                if (children_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected child: %s", $realtime, child_text(got));
                end
                else
                begin
                    want = children_due.pop_front();
                    children_checked++;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("[%0t] child mismatch\n  expected %s\n  actual   %s",
                                     $realtime, child_text(want), child_text(got));
                    end
                end
            end
        end
    end

    // Hold the output off for a long stretch so the block backs up into its input
    initial
    begin : long_hold
        while (parents_taken < HOLD_AFTER)
            @(posedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out <= 1'b0;
    end

    initial
    begin : stimulus
        longint bx;
        longint by;
        longint vx;
        longint vy;
        longint sgn;
        logic   timed_out;

        // Directed: range ends, true pinwheel shapes, degenerate and tie cases
        add_parent(0, 0, 0, 0, 0, 0);
        add_parent(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        add_parent(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        add_parent(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX);
        add_parent(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN);
        add_parent(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN);
        add_parent(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, 0, COORD_MAX);
        add_parent(0, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        add_parent(0, 0, 2 * UNIT, 0, 2 * UNIT, UNIT);
        add_parent(0, 0, 2 * UNIT, 0, 2 * UNIT, -UNIT);
        add_parent(-UNIT, UNIT, -UNIT, 3 * UNIT, -2 * UNIT, 3 * UNIT);
        add_parent(3 * UNIT, -UNIT, UNIT, -UNIT, UNIT, -2 * UNIT);
        // collinear corners and a single repeated point
        add_parent(0, 0, 1000, 2000, 3000, 6000);
        add_parent(-7000, 500, 1000, 500, 9000, 500);
        add_parent(12345, -6789, 12345, -6789, 12345, -6789);
        // small odd edges land exactly on rounding ties
        add_parent(0, 0, 1, 1, 0, 0);
        add_parent(0, 0, -1, -1, 0, 0);
        add_parent(0, 0, 0, 0, 1, -1);
        add_parent(0, 0, 3, -3, 5, -5);
        add_parent(-1, -1, 1, 1, 1, -1);
        add_parent(5592405, -5592406, -5592406, 5592405, 5592405, 5592405);
        add_parent(-5592406, 5592405, 5592405, -5592406, -5592406, -5592406);

        // Random: half well-formed pinwheel triangles, the rest full-range and edge values
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    bx  = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                    by  = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                    vx  = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
                    vy  = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
                    sgn = $urandom_range(0, 1) ? 1 : -1;
                    add_parent(bx, by, bx + 2 * vx, by + 2 * vy,
                               bx + 2 * vx - sgn * vy, by + 2 * vy + sgn * vx);
                end
                5, 6, 7:
                    add_parent(random_coord(), random_coord(), random_coord(),
                               random_coord(), random_coord(), random_coord());
                default:
                    add_parent(edge_coord(), edge_coord(), edge_coord(),
                               edge_coord(), edge_coord(), edge_coord());
            endcase
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every parent to go in and every child to come out
        while ((parents_to_send.size() != 0 || in_valid || children_due.size() != 0)
               && cycle_count < RUN_LIMIT)
            @(posedge clk);
        timed_out = (cycle_count >= RUN_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (timed_out)
        begin
            $display("Run stopped at cycle limit %0d with %0d children outstanding",
                     RUN_LIMIT, children_due.size());
            $display("Verification failed");
            $finish;
        end
        else
        begin
            $display("Deflated %0d parents into %0d checked children (%0d mirrored).",
                     parents_taken, children_checked, mirrored_seen);
            $display("Input backed up for %0d cycles; %0d mismatches, %0d children missing.",
                     input_stall_cycles, mismatch_count, children_due.size());
            if (mismatch_count == 0 && children_due.size() == 0)
                $display("Verification passed");
            else
                $display("Verification failed");
            $finish;
        end
    end

endmodule
